@@ sv/sdc_pkg.sv @@
// shared types, codes and constants for the sd card spi controller
`default_nettype none

package sdc_pkg;

    localparam int SDC_BLOCK_BYTES = 512;
    localparam int SDC_WAKE_BYTES  = 32;
    localparam logic [15:0] SDC_RETRY_RESET = 16'd100;

    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;

    localparam logic [7:0] OP_CMD0   = 8'h40;
    localparam logic [7:0] OP_CMD8   = 8'h40 | 8'd8;
    localparam logic [7:0] OP_CMD17  = 8'h40 | 8'd17;
    localparam logic [7:0] OP_ACMD41 = 8'h40 | 8'd41;
    localparam logic [7:0] OP_CMD55  = 8'h40 | 8'd55;
    localparam logic [7:0] OP_CMD58  = 8'h40 | 8'd58;

    localparam logic [31:0] ECHO_ARG  = 32'h0000_01AA;
    localparam logic [31:0] CCS_ARG   = 32'h4000_0000;
    localparam logic [7:0]  CRC_CMD0  = 8'h95;
    localparam logic [7:0]  CRC_CMD8  = 8'h87;
    localparam logic [7:0]  CRC_CMD58 = 8'h00;
    localparam logic [7:0]  IDLE_BYTE = 8'hFF;
    localparam logic [7:0]  DATA_TOKEN = 8'hFE;
    localparam logic [7:0]  R1_IDLE   = 8'h01;
    localparam logic [7:0]  R1_READY  = 8'h00;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_READ = 2'd1,
        ACT_XCHG = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INIT_FAIL = 2'd1,
        ST_READ_REJ  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_WAKE  = 4'd1,
        PH_PRE   = 4'd2,
        PH_CMD   = 4'd3,
        PH_POLL  = 4'd4,
        PH_EXTRA = 4'd5,
        PH_TOKEN = 4'd6,
        PH_DATA  = 4'd7,
        PH_CRC   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] block_address;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              chip_select;
        logic              high_speed;
        logic              exchange_request;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_data;
        logic              done_res;
        logic [1:0]        status;
    } res_t;

endpackage

`default_nettype wire

@@ sv/sdc_in_reg.sv @@
// input register stage holding one request
`default_nettype none

module sdc_in_reg
    import sdc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

@@ sv/sdc_core.sv @@
// controller state and per-exchange next-state logic
`default_nettype none

module sdc_core
    import sdc_pkg::*;
#(
    parameter int BLOCK_BYTES = SDC_BLOCK_BYTES,
    parameter int WAKE_BYTES  = SDC_WAKE_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        step,
    input  wire item_t       item,
    output res_t             res
);

    localparam int CNT_MAX = (BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [CNT_W-1:0] WAKE_LAST  = CNT_W'(WAKE_BYTES - 1);
    localparam logic [CNT_W-1:0] BLOCK_LAST = CNT_W'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(5);
    localparam logic [CNT_W-1:0] EXTRA_LAST = CNT_W'(3);

    phase_t           phase_reg,  phase_next;
    logic [15:0]      limit_reg,  limit_next;
    logic [15:0]      retry_reg,  retry_next;
    logic [CNT_W-1:0] bc_reg,     bc_next;
    logic [7:0]       code_reg,   code_next;
    logic [31:0]      arg_reg,    arg_next;
    logic [7:0]       reply_reg,  reply_next;
    logic [31:0]      shift_reg,  shift_next;
    logic             baddr_reg,  baddr_next;
    logic             fast_reg,   fast_next;

    logic        iss;
    logic [7:0]  iss_code;
    logic [31:0] iss_arg;
    logic        fin;
    status_t     fin_st;
    logic        cmd_done;
    logic [7:0]  rep;
    logic [31:0] shf;
    logic [15:0] retry_dec;
    logic [7:0]  frame;

    assign limit_next = cfg_wen ? cfg_wdata : limit_reg;
    assign retry_dec  = retry_reg - 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        retry_next = retry_reg;
        bc_next    = bc_reg;
        code_next  = code_reg;
        arg_next   = arg_reg;
        reply_next = reply_reg;
        shift_next = shift_reg;
        baddr_next = baddr_reg;
        fast_next  = fast_reg;
        iss        = 1'b0;
        iss_code   = OP_CMD0;
        iss_arg    = '0;
        fin        = 1'b0;
        fin_st     = ST_OK;
        cmd_done   = 1'b0;
        rep        = reply_reg;
        shf        = shift_reg;
        frame      = IDLE_BYTE;
        res        = '0;

        unique case (item.action)
            ACT_INIT:
            begin
                retry_next = limit_reg;
                fast_next  = 1'b0;
                phase_next = PH_WAKE;
                bc_next    = '0;
            end
            ACT_READ:
            begin
                iss      = 1'b1;
                iss_code = OP_CMD17;
                iss_arg  = baddr_reg ? {item.block_address[22:0], 9'd0}
                                     : item.block_address;
            end
            ACT_XCHG:
            begin
                unique case (phase_reg)
                    PH_WAKE:
                    begin
                        if (bc_reg == WAKE_LAST)
                        begin
                            // cmd0 attempt costs one from the budget
                            retry_next = retry_dec;
                            if (retry_dec == 16'd0)
                            begin
                                fin    = 1'b1;
                                fin_st = ST_INIT_FAIL;
                            end
                            else
                            begin
                                iss = 1'b1;
                            end
                        end
                        else
                        begin
                            bc_next = bc_reg + 1'b1;
                        end
                    end
                    PH_PRE:
                    begin
                        phase_next = PH_CMD;
                        bc_next    = '0;
                    end
                    PH_CMD:
                    begin
                        if (bc_reg == FRAME_LAST)
                        begin
                            phase_next = PH_POLL;
                            bc_next    = '0;
                        end
                        else
                        begin
                            bc_next = bc_reg + 1'b1;
                        end
                    end
                    PH_POLL:
                    begin
                        if (item.rx_byte != IDLE_BYTE)
                        begin
                            reply_next = item.rx_byte;
                            if (code_reg == OP_CMD8 || code_reg == OP_CMD58)
                            begin
                                phase_next = PH_EXTRA;
                                bc_next    = '0;
                            end
                            else
                            begin
                                cmd_done = 1'b1;
                                rep      = item.rx_byte;
                            end
                        end
                    end
                    PH_EXTRA:
                    begin
                        shift_next = {shift_reg[23:0], item.rx_byte};
                        if (bc_reg == EXTRA_LAST)
                        begin
                            cmd_done = 1'b1;
                            shf      = {shift_reg[23:0], item.rx_byte};
                        end
                        else
                        begin
                            bc_next = bc_reg + 1'b1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (item.rx_byte == DATA_TOKEN)
                        begin
                            phase_next = PH_DATA;
                            bc_next    = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        res.data_valid = 1'b1;
                        res.data_byte  = item.rx_byte;
                        if (bc_reg == BLOCK_LAST)
                        begin
                            res.last_data = 1'b1;
                            phase_next    = PH_CRC;
                            bc_next       = '0;
                        end
                        else
                        begin
                            bc_next = bc_reg + 1'b1;
                        end
                    end
                    PH_CRC:
                    begin
                        if (bc_reg != '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            bc_next = CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        // idle: exchange report ignored
                    end
                endcase
            end
            default:
            begin
                // unused action code: ignored
            end
        endcase

        // full reply received: pick the next command
        if (cmd_done)
        begin
            unique case (code_reg)
                OP_CMD0:
                begin
                    if (rep == R1_IDLE)
                    begin
                        iss      = 1'b1;
                        iss_code = OP_CMD8;
                        iss_arg  = ECHO_ARG;
                    end
                    else
                    begin
                        retry_next = retry_dec;
                        if (retry_dec == 16'd0)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_INIT_FAIL;
                        end
                        else
                        begin
                            iss = 1'b1;
                        end
                    end
                end
                OP_CMD8:
                begin
                    if (rep[7:1] == 7'd0 && shf[9:0] == ECHO_ARG[9:0])
                    begin
                        iss      = 1'b1;
                        iss_code = OP_CMD55;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_st = ST_INIT_FAIL;
                    end
                end
                OP_CMD55:
                begin
                    iss      = 1'b1;
                    iss_code = OP_ACMD41;
                    iss_arg  = CCS_ARG;
                end
                OP_ACMD41:
                begin
                    if (rep == R1_IDLE)
                    begin
                        iss      = 1'b1;
                        iss_code = OP_CMD55;
                    end
                    else if (rep == R1_READY)
                    begin
                        iss      = 1'b1;
                        iss_code = OP_CMD58;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_st = ST_INIT_FAIL;
                    end
                end
                OP_CMD58:
                begin
                    fin = 1'b1;
                    if (rep == R1_READY)
                    begin
                        baddr_next = !shf[30];
                        fast_next  = 1'b1;
                    end
                    else
                    begin
                        fin_st = ST_INIT_FAIL;
                    end
                end
                OP_CMD17:
                begin
                    if (rep != R1_READY)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_READ_REJ;
                    end
                    else
                    begin
                        phase_next = PH_TOKEN;
                        bc_next    = '0;
                    end
                end
                default:
                begin
                    fin    = 1'b1;
                    fin_st = ST_INIT_FAIL;
                end
            endcase
        end

        if (iss)
        begin
            code_next  = iss_code;
            arg_next   = iss_arg;
            phase_next = PH_PRE;
            bc_next    = '0;
        end

        if (fin)
        begin
            phase_next = PH_IDLE;
            bc_next    = '0;
        end

        // framed command byte for the next exchange
        if (bc_next == CNT_W'(0))
        begin
            frame = code_next;
        end
        else if (bc_next == CNT_W'(1))
        begin
            frame = arg_next[31:24];
        end
        else if (bc_next == CNT_W'(2))
        begin
            frame = arg_next[23:16];
        end
        else if (bc_next == CNT_W'(3))
        begin
            frame = arg_next[15:8];
        end
        else if (bc_next == CNT_W'(4))
        begin
            frame = arg_next[7:0];
        end
        else if (code_next == OP_CMD58)
        begin
            frame = CRC_CMD58;
        end
        else if (code_next == OP_CMD8)
        begin
            frame = CRC_CMD8;
        end
        else
        begin
            frame = CRC_CMD0;
        end

        res.high_speed       = fast_next;
        res.tx_byte          = (phase_next == PH_CMD) ? frame : IDLE_BYTE;
        res.exchange_request = (phase_next != PH_IDLE);
        res.chip_select      = (phase_next != PH_IDLE) && (phase_next != PH_WAKE)
                               && (phase_next != PH_PRE);
        res.done_res         = fin;
        res.status           = fin ? fin_st : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= SDC_RETRY_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            retry_reg <= '0;
            bc_reg    <= '0;
            code_reg  <= '0;
            arg_reg   <= '0;
            reply_reg <= IDLE_BYTE;
            shift_reg <= '0;
            baddr_reg <= 1'b1;
            fast_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            retry_reg <= retry_next;
            bc_reg    <= bc_next;
            code_reg  <= code_next;
            arg_reg   <= arg_next;
            reply_reg <= reply_next;
            shift_reg <= shift_next;
            baddr_reg <= baddr_next;
            fast_reg  <= fast_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sdc_out_reg.sv @@
// result register stage toward the downstream receiver
`default_nettype none

module sdc_out_reg
    import sdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire res_t load_res,
    output logic      can_load,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ sv/sd_card_spi_init_and_block_read_top.sv @@
// top level of the sd card spi-mode init and block read controller
//
// usage: every request on the slave stream is one step of the spi master.
// tuser carries the action: start init, start block read, or byte exchange
// done (with the received byte in tdata). each request yields exactly one
// result on the master stream: the next byte to shift out, chip select,
// whether another exchange is wanted, high speed, block data byte with
// tlast on the final one, and done plus status at the end of an operation.
// a request is first captured in the input register, then processed into the
// result register once that register can take it, and offered from there.
// throughput: one request per cycle while the result side is not stalled; the
// next-state logic is a single pass per request. in use each request is one
// spi byte exchange, so the link, not this block, sets the pace.
// a stalled master side holds its result while the input register still
// takes one more request, after which tready drops until the result moves.
// reset clears all control state: idle, byte addressing, slow link,
// retry limit back to 100. cfg_wen/cfg_wdata load the cmd0 retry limit; the
// user must write them only while no request is in flight; the block does not enforce it.
`default_nettype none

module sd_card_spi_init_and_block_read_top
    import sdc_pkg::*;
#(
    parameter int BLOCK_BYTES = SDC_BLOCK_BYTES,
    parameter int WAKE_BYTES  = SDC_WAKE_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // cmd0 retry limit
    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // block_address[31:0], rx_byte[39:32]
    input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tx_byte[7:0], chip_select[8], high_speed[9], exchange_request[10],
    // data_byte[18:11], done_res[19], status[21:20], zero[23:22]
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tuser,  // data_valid
    output logic             m_axis_tlast   // last_data
);

    item_t in_item;
    item_t held_item;
    logic  held_valid;
    logic  advance;
    logic  can_load;
    res_t  step_res;
    res_t  out_res;

    assign in_item.action        = s_axis_tuser;
    assign in_item.block_address = s_axis_tdata[31:0];
    assign in_item.rx_byte       = s_axis_tdata[39:32];

    // a held request is processed when the result register can take it
    assign advance = held_valid && can_load;

    sdc_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sdc_core
    #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .WAKE_BYTES  (WAKE_BYTES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (held_item),
        .res       (step_res)
    );

    sdc_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_res  (step_res),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.status, out_res.done_res, out_res.data_byte,
                           out_res.exchange_request, out_res.high_speed,
                           out_res.chip_select, out_res.tx_byte};
    assign m_axis_tuser = out_res.data_valid;
    assign m_axis_tlast = out_res.last_data;

`ifndef ASSERT_OFF
    // an accepted request is held in the input register in the next cycle
    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> held_valid)
        else $error("accepted request not held");

    // a held request moves into an empty result register
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("held request did not reach result register");

    // last block byte is always a data byte
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("tlast without data");

    // no exchange wanted means select released and idle byte
    a_idle_link: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[10]) |->
            (!m_axis_tdata[8] && m_axis_tdata[7:0] == IDLE_BYTE))
        else $error("select or data driven while no exchange wanted");
`endif

endmodule

`default_nettype wire
